// File: hdl/sie_pkg.sv
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and constants for the set intersection engine: operation
// codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package sie_pkg;

  // Item payload widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;

  // Default number of store entries
  localparam int unsigned STORE_DEPTH_DEFAULT = 64;

  // Operation codes carried in func (the remaining code is a no-op)
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PROBE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } sie_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming item, restart the scan
    logic scan;    // issue a store read at the scan counter
    logic commit;  // update the store and load the result register
  } sie_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_func;   // held item is an insert or a probe
    logic issue_done;  // a read has been issued for every entry
    logic rd_pending;  // a store read is in flight
    logic hit;         // value found in a valid entry
    logic out_free;    // result register can take a new item
  } sie_status_t;

endpackage

// File: hdl/set_intersection_engine.sv
// ----------------------------------------------------------------------------
// set_intersection_engine
// Bounded membership store that reports the distinct intersection of two
// integer streams.
// ----------------------------------------------------------------------------
// Usage: send the first array as insert items (func 0), then the second
// array as probe items (func 1); a probe that finds its value removes it
// and returns matched = 1, so each common value is reported once. A clear
// item (func 2) empties the store between problems. An insert of a new
// value into a full store is dropped and returns overflow = 1. Every item
// gives one result, with final_result copying last_item.
// Channels: input (in_valid/in_ready with func, value, last_item) and
// output (out_valid/out_ready with matched, result_value, overflow,
// final_result), both valid/ready.
// Timing: one item at a time. Inserts and probes read the store one entry
// per cycle through its single read port and sweep every entry unless a
// match stops the scan early; clear and no-op items skip the scan.
// The next item is accepted the cycle after a result is loaded, even while
// that result waits in the output register. If the receiver stalls with a
// result still held, the finished item waits until the register frees.
// Reset: the store is empty, no result is pending and no item is accepted.
// ----------------------------------------------------------------------------
module set_intersection_engine
  import sie_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      matched,
  output logic signed [VALUE_W-1:0] result_value,
  output logic                      overflow,
  output logic                      final_result
);

  sie_cmd_t    cmd;
  sie_status_t status;

  // Sequencer
  sie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Store, scan and result register
  sie_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .func         (func),
    .value        (value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .matched      (matched),
    .result_value (result_value),
    .overflow     (overflow),
    .final_result (final_result)
  );

endmodule

// File: hdl/sie_ram.sv
// ----------------------------------------------------------------------------
// sie_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sie_ctrl.sv
// ----------------------------------------------------------------------------
// sie_ctrl
// Controller for the set intersection engine: accepts an item, runs the
// store scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module sie_ctrl
  import sie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output sie_cmd_t    cmd,
  input  sie_status_t status
);

  sie_state_t state;
  sie_state_t state_next;
  logic       scan_finished;

  // Scan ends when no lookup is needed, or on a hit / full sweep once drained
  assign scan_finished = !status.scan_func ||
                         ((status.hit || status.issue_done) && !status.rd_pending);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_finished) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs; hold the input off while in reset
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_SCAN: begin
        cmd.scan = status.scan_func && !status.hit && !status.issue_done;
      end
      ST_DONE: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/sie_datapath.sv
// ----------------------------------------------------------------------------
// sie_datapath
// Datapath for the set intersection engine: item registers, store RAM,
// valid bits, sequential scan with match and free-slot tracking, and the
// result register.
// ----------------------------------------------------------------------------
module sie_datapath
  import sie_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sie_cmd_t                  cmd,
  output sie_status_t               status,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      matched,
  output logic signed [VALUE_W-1:0] result_value,
  output logic                      overflow,
  output logic                      final_result
);

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  // Held item
  logic [FUNC_W-1:0]         item_func;
  logic signed [VALUE_W-1:0] item_value;
  logic                      item_last;

  // Scan state
  logic [CNT_W-1:0]       cnt;
  logic                   rd_pending;
  logic [IDX_W-1:0]       rd_idx;
  logic [VALUE_W-1:0]     rdata;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   entry_match;
  logic                   entry_free;

  // Store occupancy
  logic [STORE_DEPTH-1:0] valid;
  logic [STORE_DEPTH-1:0] valid_next;

  // Commit decode
  logic                   is_insert;
  logic                   is_probe;
  logic                   do_write;
  logic                   out_valid_next;

  assign is_insert = (item_func == FUNC_INSERT);
  assign is_probe  = (item_func == FUNC_PROBE);
  assign do_write  = cmd.commit && is_insert && !hit && free_found;

  // Compare stage on the returned read data
  assign entry_match = valid[rd_idx] && (rdata == $unsigned(item_value));
  assign entry_free  = !valid[rd_idx];

  // Value store
  sie_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (free_idx),
    .wdata ($unsigned(item_value)),
    .re    (cmd.scan),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Status to controller
  assign status.scan_func  = is_insert || is_probe;
  assign status.issue_done = (cnt == CNT_W'(STORE_DEPTH));
  assign status.rd_pending = rd_pending;
  assign status.hit        = hit;
  assign status.out_free   = !out_valid || out_ready;

  // Store update applied at commit
  always_comb begin
    valid_next = valid;
    case (item_func)
      FUNC_INSERT: begin
        if (!hit && free_found) begin
          valid_next[free_idx] = 1'b1;
        end
      end
      FUNC_PROBE: begin
        if (hit) begin
          valid_next[hit_idx] = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        valid_next = '0;
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  // Result register handshake: load on commit, drop when taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_pending <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= cmd.scan;
      if (cmd.load) begin
        cnt        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan) begin
          cnt <= cnt + 1'b1;
        end
        if (rd_pending && !hit && entry_match) begin
          hit <= 1'b1;
        end
        if (rd_pending && !free_found && entry_free) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        valid <= valid_next;
      end
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func  <= func;
      item_value <= value;
      item_last  <= last_item;
    end
    if (cmd.scan) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (rd_pending && !hit && entry_match) begin
      hit_idx <= rd_idx;
    end
    if (rd_pending && !free_found && entry_free) begin
      free_idx <= rd_idx;
    end
    if (cmd.commit) begin
      matched      <= is_probe && hit;
      result_value <= item_value;
      overflow     <= is_insert && !hit && !free_found;
      final_result <= item_last;
    end
  end

endmodule

// File: bench/set_intersection_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_intersection_engine_test
// Runs inserts, probes, clears and no-op items through the engine and checks
// every result against a local model of the membership store. A short table
// of hand-picked items comes first. Random problems follow: most open with a
// clear, then a first array of inserts, then a second array of probes drawn
// mostly from the inserted values with some noise. Both channels idle at
// random, and once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module set_intersection_engine_test;
  import sie_pkg::*;

  localparam int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT;

  // Unused operation code; the engine treats it as a no-op
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam int RESET_CYCLES   = 11;
  localparam int TOTAL_ITEMS    = 850;
  localparam int CALM_FROM      = 250;
  localparam int CALM_TO        = 400;
  localparam int HOLDOFF_AT     = 600;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = STORE_DEPTH + 8;
  localparam int CYCLE_LIMIT    = 500000;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } isect_item_t;

  typedef struct packed {
    logic                      matched;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
    logic                      last_flag;
  } isect_result_t;

  // One stimulus row; typed rows carry their own matched and overflow
  typedef struct packed {
    isect_item_t item;
    logic        typed;
    logic        matched;
    logic        overflow;
  } isect_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func = FUNC_INSERT;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      last_item = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      matched;
  logic signed [VALUE_W-1:0] result_value;
  logic                      overflow;
  logic                      final_result;

  // Local copy of the membership store
  logic [VALUE_W-1:0] store_vals [STORE_DEPTH];
  bit                 store_used [STORE_DEPTH];

  isect_result_t awaited_results [$];
  isect_row_t    directed_rows [$];
  int            accepted_count = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  set_intersection_engine #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .value(value),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .matched(matched),
    .result_value(result_value),
    .overflow(overflow),
    .final_result(final_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stretch of the run with no idling on either side
  function automatic bit calm_window();
    return accepted_count >= CALM_FROM && accepted_count < CALM_TO;
  endfunction

  function automatic isect_row_t make_row(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                          logic l, logic t, logic m, logic o);
    isect_row_t r;
    r.item.func  = f;
    r.item.value = v;
    r.item.last  = l;
    r.typed      = t;
    r.matched    = m;
    r.overflow   = o;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                  logic l, logic t, logic m, logic o);
    directed_rows.insert(directed_rows.size(), make_row(f, v, l, t, m, o));
  endfunction

  // Replace a few items with arbitrary ones, no-ops included
  function automatic isect_row_t scramble(isect_row_t row);
    isect_row_t r;
    r = row;
    if ($urandom_range(0, 99) < 7) begin
      r.item.func  = FUNC_W'($urandom_range(FUNC_INSERT, FUNC_NOP));
      r.item.value = $urandom;
      r.item.last  = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // Apply one item to the local store and return the result it yields
  function automatic isect_result_t apply_to_store(isect_item_t it);
    isect_result_t r;
    int            hit;
    int            slot;
    r.matched   = 1'b0;
    r.value     = it.value;
    r.overflow  = 1'b0;
    r.last_flag = it.last;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (hit < 0 && store_used[i] && store_vals[i] == it.value) hit = i;
      if (slot < 0 && !store_used[i]) slot = i;
    end
    case (it.func)
      FUNC_INSERT: begin
        if (hit < 0) begin
          if (slot < 0) begin
            r.overflow = 1'b1;
          end else begin
            store_vals[slot] = it.value;
            store_used[slot] = 1'b1;
          end
        end
      end
      FUNC_PROBE: begin
        if (hit >= 0) begin
          store_used[hit] = 1'b0;
          r.matched = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < STORE_DEPTH; i++) store_used[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one item, wait for it to be taken, then log its expected result
  task automatic offer_item(isect_row_t row);
    isect_result_t want;
    @(negedge clk);
    if (!calm_window() && $urandom_range(0, 99) < 6) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    func      = row.item.func;
    value     = row.item.value;
    last_item = row.item.last;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = apply_to_store(row.item);
    if (row.typed) begin
      want.matched   = row.matched;
      want.value     = row.item.value;
      want.overflow  = row.overflow;
      want.last_flag = row.item.last;
    end
    awaited_results.insert(awaited_results.size(), want);
    accepted_count++;
  endtask

  function automatic void compare_field(string name, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin : result_check
    isect_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got value %h",
                 $time, result_value);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("matched", VALUE_W'(want.matched), VALUE_W'(matched));
        compare_field("result_value", want.value, result_value);
        compare_field("overflow", VALUE_W'(want.overflow), VALUE_W'(overflow));
        compare_field("final_result", VALUE_W'(want.last_flag), VALUE_W'(final_result));
      end
    end
  end

  // Drive out_ready: random stalls, a calm stretch and one long hold-off
  initial begin : result_sink
    int  stall_left;
    bit  stall_used;
    stall_left = 0;
    stall_used = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_used && accepted_count >= HOLDOFF_AT) begin
        stall_used = 1'b1;
        stall_left = HOLDOFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rst || calm_window()) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    isect_row_t         row;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] v;
    int                 first_len;
    int                 second_len;
    int                 span;
    int                 problem;
    bit                 big;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes of the value, a duplicate insert, then an end of array
    add_row(FUNC_INSERT, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_INSERT, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_INSERT, 32'h5555_5555, 1'b1, 1'b1, 1'b0, 1'b0);
    // Hit, repeated probe of a removed value, plain miss, another hit
    add_row(FUNC_PROBE, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0);
    add_row(FUNC_PROBE, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'h1234_5678, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b0);
    // No-op must not touch the store
    add_row(FUNC_NOP, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0);
    add_row(FUNC_PROBE, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 1'b0);
    // Clear empties the store
    add_row(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'h5555_5555, 1'b1, 1'b1, 1'b0, 1'b0);
    // Short problem left to the model
    add_row(FUNC_INSERT, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INSERT, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_NOP, 32'h0F0F_0F0F, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_PROBE, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_CLEAR, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    foreach (directed_rows[i]) offer_item(directed_rows[i]);

    // Random problems; the first one overfills the store
    problem = 0;
    while (accepted_count < TOTAL_ITEMS) begin
      big = (problem == 0) || ($urandom_range(0, 99) < 15);
      first_len = big ? $urandom_range(56, 80) : $urandom_range(1, 12);
      if (problem == 0) first_len = 70;
      span = big ? first_len + 8 : first_len + 2;
      base = $urandom;

      // Most problems start from an empty store
      if (problem == 0 || $urandom_range(0, 99) < 80) begin
        offer_item(make_row(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)),
                            1'b0, 1'b0, 1'b0));
      end

      for (int k = 0; k < first_len; k++) begin
        if (big && $urandom_range(0, 99) >= 5) v = base + k;
        else v = base + $urandom_range(0, span);
        row = make_row(FUNC_INSERT, v, k == first_len - 1, 1'b0, 1'b0, 1'b0);
        offer_item(scramble(row));
      end

      second_len = big ? $urandom_range(8, 24) : $urandom_range(1, 12);
      for (int k = 0; k < second_len; k++) begin
        if ($urandom_range(0, 99) < 60) v = base + $urandom_range(0, span);
        else v = $urandom;
        row = make_row(FUNC_PROBE, v, k == second_len - 1, 1'b0, 1'b0, 1'b0);
        offer_item(scramble(row));
      end
      problem++;
    end

    @(negedge clk);
    in_valid = 1'b0;

    // Drain outstanding results, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sie_pkg.sv
hdl/sie_ram.sv
hdl/sie_ctrl.sv
hdl/sie_datapath.sv
hdl/set_intersection_engine.sv
bench/set_intersection_engine_test.sv
